// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define SBCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Value must be unchanged in the cycle after cond is seen.
`define SBCT_ASSERT_STABLE(lbl, clk, rstn, cond, sig, msg) \
  `SBCT_ASSERT(lbl, clk, rstn, (cond) |=> $stable(sig), msg)

`endif

// File: hdl/sbct_pkg.sv
`default_nettype none

package sbct_pkg;

  localparam int unsigned DefCoordWidth   = 24;
  localparam int unsigned DefTimeFracBits = 16;
  localparam int unsigned ResolveStages   = 5;

  typedef struct packed {
    logic vzero;
    logic zx;
    logic zy;
    logic inx;
    logic iny;
    logic negxn;
    logic negxf;
    logic negyn;
    logic negyf;
  } flags_t;

endpackage

`default_nettype wire

// File: hdl/sbct_in_if.sv
`default_nettype none

interface sbct_in_if #(
  parameter int unsigned CW = sbct_pkg::DefCoordWidth,
  parameter int unsigned TF = sbct_pkg::DefTimeFracBits
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] mover_x;
  logic signed [CW-1:0] mover_y;
  logic        [CW-2:0] mover_width;
  logic        [CW-2:0] mover_height;
  logic signed [CW-1:0] vel_x;
  logic signed [CW-1:0] vel_y;
  logic signed [CW-1:0] target_x;
  logic signed [CW-1:0] target_y;
  logic        [CW-2:0] target_width;
  logic        [CW-2:0] target_height;
  logic        [TF:0]   elapsed_time;

  modport source (
    output valid, mover_x, mover_y, mover_width, mover_height, vel_x, vel_y,
           target_x, target_y, target_width, target_height, elapsed_time,
    input  ready
  );

  modport sink (
    input  valid, mover_x, mover_y, mover_width, mover_height, vel_x, vel_y,
           target_x, target_y, target_width, target_height, elapsed_time,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/sbct_out_if.sv
`default_nettype none

interface sbct_out_if #(
  parameter int unsigned CW = sbct_pkg::DefCoordWidth,
  parameter int unsigned TF = sbct_pkg::DefTimeFracBits
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [CW-1:0] contact_x;
  logic signed [CW-1:0] contact_y;
  logic signed [1:0]    normal_x;
  logic signed [1:0]    normal_y;
  logic        [TF:0]   touch_time;

  modport source (
    output valid, hit, contact_x, contact_y, normal_x, normal_y, touch_time,
    input  ready
  );

  modport sink (
    input  valid, hit, contact_x, contact_y, normal_x, normal_y, touch_time,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/swept_box_collision_test_core.sv
`default_nettype none

// Swept box test: grows the target by the mover's size and runs a slab test on
// the ray from the mover's center along velocity times the time step, giving hit,
// contact point, face normal and contact time. One item is taken per clock while
// in_i.ready is high, and results leave in input order after the entry stage, the
// four slab dividers and the resolve stages. The dividers run in parallel and
// retire one quotient bit per stage; each stage holds its own valid bit, so stalls
// from the output side fill bubbles before the input is held off.
module swept_box_collision_test_core #(
  parameter int unsigned COORD_WIDTH    = sbct_pkg::DefCoordWidth,
  parameter int unsigned TIME_FRAC_BITS = sbct_pkg::DefTimeFracBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbct_in_if.sink    in_i,
  sbct_out_if.source out_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned TF = TIME_FRAC_BITS;
  localparam int unsigned DS = TF + 3;
  localparam int unsigned RS = sbct_pkg::ResolveStages;
  localparam int unsigned NS = 1 + DS + RS;

  typedef struct packed {
    sbct_pkg::flags_t     flags;
    logic signed [CW:0]   cx;
    logic signed [CW:0]   cy;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic        [TF:0]   el;
  } side_t;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = v_q[NS-1];

  logic [CW+1:0]  anx, afx, any, afy;
  logic [CW+TF:0] dx, dy;
  side_t          side_in, side_out;

  sbct_prep #(.CW(CW), .TF(TF)) u_prep (
    .clk_i           (clk_i),
    .en_i            (rdy[0]),
    .mover_x_i       (in_i.mover_x),
    .mover_y_i       (in_i.mover_y),
    .mover_width_i   (in_i.mover_width),
    .mover_height_i  (in_i.mover_height),
    .vel_x_i         (in_i.vel_x),
    .vel_y_i         (in_i.vel_y),
    .target_x_i      (in_i.target_x),
    .target_y_i      (in_i.target_y),
    .target_width_i  (in_i.target_width),
    .target_height_i (in_i.target_height),
    .elapsed_time_i  (in_i.elapsed_time),
    .anx_o           (anx),
    .afx_o           (afx),
    .any_o           (any),
    .afy_o           (afy),
    .dx_o            (dx),
    .dy_o            (dy),
    .flags_o         (side_in.flags),
    .cx_o            (side_in.cx),
    .cy_o            (side_in.cy),
    .vx_o            (side_in.vx),
    .vy_o            (side_in.vy),
    .el_o            (side_in.el)
  );

  logic [TF+1:0] qxn, qxf, qyn, qyf;
  logic [3:0]    rnz, ovf;

  sbct_div #(.CW(CW), .TF(TF)) u_div_xn (
    .clk_i (clk_i), .en_i (rdy[1 +: DS]), .a_i (anx), .d_i (dx),
    .q_o (qxn), .rem_nz_o (rnz[0]), .ovf_o (ovf[0])
  );

  sbct_div #(.CW(CW), .TF(TF)) u_div_xf (
    .clk_i (clk_i), .en_i (rdy[1 +: DS]), .a_i (afx), .d_i (dx),
    .q_o (qxf), .rem_nz_o (rnz[1]), .ovf_o (ovf[1])
  );

  sbct_div #(.CW(CW), .TF(TF)) u_div_yn (
    .clk_i (clk_i), .en_i (rdy[1 +: DS]), .a_i (any), .d_i (dy),
    .q_o (qyn), .rem_nz_o (rnz[2]), .ovf_o (ovf[2])
  );

  sbct_div #(.CW(CW), .TF(TF)) u_div_yf (
    .clk_i (clk_i), .en_i (rdy[1 +: DS]), .a_i (afy), .d_i (dy),
    .q_o (qyf), .rem_nz_o (rnz[3]), .ovf_o (ovf[3])
  );

  sbct_delay #(.W($bits(side_t)), .N(DS)) u_side (
    .clk_i (clk_i),
    .en_i  (rdy[1 +: DS]),
    .d_i   (side_in),
    .q_o   (side_out)
  );

  sbct_resolve #(.CW(CW), .TF(TF)) u_resolve (
    .clk_i        (clk_i),
    .en_i         (rdy[1 + DS +: RS]),
    .qxn_i        (qxn),
    .qxf_i        (qxf),
    .qyn_i        (qyn),
    .qyf_i        (qyf),
    .rnz_i        (rnz),
    .ovf_i        (ovf),
    .flags_i      (side_out.flags),
    .cx_i         (side_out.cx),
    .cy_i         (side_out.cy),
    .vx_i         (side_out.vx),
    .vy_i         (side_out.vy),
    .el_i         (side_out.el),
    .hit_o        (out_o.hit),
    .contact_x_o  (out_o.contact_x),
    .contact_y_o  (out_o.contact_y),
    .normal_x_o   (out_o.normal_x),
    .normal_y_o   (out_o.normal_y),
    .touch_time_o (out_o.touch_time)
  );

endmodule

`default_nettype wire

// File: hdl/sbct_prep.sv
`default_nettype none

// Entry stage: slab numerator magnitudes, divisors, case flags and the mover's center, velocity and time step.
module sbct_prep #(
  parameter int unsigned CW = sbct_pkg::DefCoordWidth,
  parameter int unsigned TF = sbct_pkg::DefTimeFracBits
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] mover_x_i,
  input  logic signed [CW-1:0] mover_y_i,
  input  logic        [CW-2:0] mover_width_i,
  input  logic        [CW-2:0] mover_height_i,
  input  logic signed [CW-1:0] vel_x_i,
  input  logic signed [CW-1:0] vel_y_i,
  input  logic signed [CW-1:0] target_x_i,
  input  logic signed [CW-1:0] target_y_i,
  input  logic        [CW-2:0] target_width_i,
  input  logic        [CW-2:0] target_height_i,
  input  logic        [TF:0]   elapsed_time_i,
  output logic        [CW+1:0] anx_o,
  output logic        [CW+1:0] afx_o,
  output logic        [CW+1:0] any_o,
  output logic        [CW+1:0] afy_o,
  output logic        [CW+TF:0] dx_o,
  output logic        [CW+TF:0] dy_o,
  output sbct_pkg::flags_t     flags_o,
  output logic signed [CW:0]   cx_o,
  output logic signed [CW:0]   cy_o,
  output logic signed [CW-1:0] vx_o,
  output logic signed [CW-1:0] vy_o,
  output logic        [TF:0]   el_o
);

  localparam int unsigned NW = CW + 2;
  localparam int unsigned DW = CW + TF + 1;

  logic signed [NW-1:0] mx, my, tx, ty, mw, mh, tw, th;
  logic signed [NW-1:0] nxn, nxf, nyn, nyf;
  logic        [CW-1:0] vax, vay;
  logic                 ezero;
  sbct_pkg::flags_t     flags_d;

  assign mx = {{2{mover_x_i[CW-1]}}, mover_x_i};
  assign my = {{2{mover_y_i[CW-1]}}, mover_y_i};
  assign tx = {{2{target_x_i[CW-1]}}, target_x_i};
  assign ty = {{2{target_y_i[CW-1]}}, target_y_i};
  assign mw = {3'b000, mover_width_i};
  assign mh = {3'b000, mover_height_i};
  assign tw = {3'b000, target_width_i};
  assign th = {3'b000, target_height_i};

  assign nxn = tx - mx - mw;
  assign nxf = tx + tw - mx;
  assign nyn = ty - my - mh;
  assign nyf = ty + th - my;

  assign vax   = vel_x_i[CW-1] ? CW'(-vel_x_i) : CW'(vel_x_i);
  assign vay   = vel_y_i[CW-1] ? CW'(-vel_y_i) : CW'(vel_y_i);
  assign ezero = (elapsed_time_i == '0);

  always_comb begin
    flags_d.vzero = (vel_x_i == '0) && (vel_y_i == '0);
    flags_d.zx    = (vel_x_i == '0) || ezero;
    flags_d.zy    = (vel_y_i == '0) || ezero;
    flags_d.inx   = nxn[NW-1] && !nxf[NW-1] && (nxf != '0);
    flags_d.iny   = nyn[NW-1] && !nyf[NW-1] && (nyf != '0);
    flags_d.negxn = (nxn != '0) && (nxn[NW-1] != vel_x_i[CW-1]);
    flags_d.negxf = (nxf != '0) && (nxf[NW-1] != vel_x_i[CW-1]);
    flags_d.negyn = (nyn != '0) && (nyn[NW-1] != vel_y_i[CW-1]);
    flags_d.negyf = (nyf != '0) && (nyf[NW-1] != vel_y_i[CW-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      anx_o   <= nxn[NW-1] ? NW'(-nxn) : NW'(nxn);
      afx_o   <= nxf[NW-1] ? NW'(-nxf) : NW'(nxf);
      any_o   <= nyn[NW-1] ? NW'(-nyn) : NW'(nyn);
      afy_o   <= nyf[NW-1] ? NW'(-nyf) : NW'(nyf);
      dx_o    <= DW'(vax) * DW'(elapsed_time_i);
      dy_o    <= DW'(vay) * DW'(elapsed_time_i);
      flags_o <= flags_d;
      cx_o    <= $signed({mover_x_i[CW-1], mover_x_i}) + $signed({3'b000, mover_width_i[CW-2:1]});
      cy_o    <= $signed({mover_y_i[CW-1], mover_y_i}) + $signed({3'b000, mover_height_i[CW-2:1]});
      vx_o    <= vel_x_i;
      vy_o    <= vel_y_i;
      el_o    <= elapsed_time_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sbct_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage, after a range check stage.
// Quotient is floor((a << 2*TF) / d) when ovf_o is low.
module sbct_div #(
  parameter int unsigned CW = sbct_pkg::DefCoordWidth,
  parameter int unsigned TF = sbct_pkg::DefTimeFracBits
) (
  input  logic              clk_i,
  input  logic [TF+2:0]     en_i,
  input  logic [CW+1:0]     a_i,
  input  logic [CW+TF:0]    d_i,
  output logic [TF+1:0]     q_o,
  output logic              rem_nz_o,
  output logic              ovf_o
);

  localparam int unsigned NW   = CW + 2;
  localparam int unsigned DW   = CW + TF + 1;
  localparam int unsigned QB   = TF + 2;
  localparam int unsigned RW   = CW + 2 * TF + 3;
  localparam int unsigned NSTG = QB + 1;

  logic [RW-1:0] r_q   [NSTG];
  logic [DW-1:0] dd_q  [NSTG];
  logic [QB-1:0] q_q   [NSTG];
  logic          ovf_q [NSTG];

  logic [RW-1:0] a_w;

  assign a_w = RW'({a_i, {(2*TF){1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]   <= a_w;
      dd_q[0]  <= d_i;
      q_q[0]   <= '0;
      ovf_q[0] <= (a_w >= (RW'(d_i) << QB));
    end
  end

  for (genvar j = 1; j < NSTG; j++) begin : g_bit
    localparam int unsigned K = QB - j;
    logic [RW-1:0] sub;
    logic          take;

    assign sub  = RW'(dd_q[j-1]) << K;
    assign take = (r_q[j-1] >= sub);

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        r_q[j]   <= take ? (r_q[j-1] - sub) : r_q[j-1];
        dd_q[j]  <= dd_q[j-1];
        q_q[j]   <= q_q[j-1] | (QB'(take) << K);
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign q_o      = q_q[NSTG-1];
  assign rem_nz_o = (r_q[NSTG-1] != '0);
  assign ovf_o    = ovf_q[NSTG-1];

endmodule

`default_nettype wire

// File: hdl/sbct_delay.sv
`default_nettype none

// Sideband line that runs beside the dividers, one register per stage.
module sbct_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  logic         clk_i,
  input  logic [N-1:0] en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pipe_q[0] <= d_i;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

`default_nettype wire

// File: hdl/sbct_resolve.sv
`default_nettype none

// Slab times to hit decision, normal, contact time and contact point.
module sbct_resolve #(
  parameter int unsigned CW = sbct_pkg::DefCoordWidth,
  parameter int unsigned TF = sbct_pkg::DefTimeFracBits
) (
  input  logic                               clk_i,
  input  logic [sbct_pkg::ResolveStages-1:0] en_i,
  input  logic        [TF+1:0]               qxn_i,
  input  logic        [TF+1:0]               qxf_i,
  input  logic        [TF+1:0]               qyn_i,
  input  logic        [TF+1:0]               qyf_i,
  input  logic        [3:0]                  rnz_i,
  input  logic        [3:0]                  ovf_i,
  input  sbct_pkg::flags_t                   flags_i,
  input  logic signed [CW:0]                 cx_i,
  input  logic signed [CW:0]                 cy_i,
  input  logic signed [CW-1:0]               vx_i,
  input  logic signed [CW-1:0]               vy_i,
  input  logic        [TF:0]                 el_i,
  output logic                               hit_o,
  output logic signed [CW-1:0]               contact_x_o,
  output logic signed [CW-1:0]               contact_y_o,
  output logic signed [1:0]                  normal_x_o,
  output logic signed [1:0]                  normal_y_o,
  output logic        [TF:0]                 touch_time_o
);

  localparam int unsigned QB  = TF + 2;
  localparam int unsigned TW  = TF + 3;
  localparam int unsigned EW  = TF + 1;
  localparam int unsigned PW  = CW + TF + 2;
  localparam int unsigned DPW = CW + 2;
  localparam int unsigned SW  = CW + 3;

  localparam logic signed [TW-1:0] TOne  = TW'(1) << TF;
  localparam logic signed [TW-1:0] THigh = TW'(1) << (TF + 1);
  localparam logic signed [TW-1:0] TLow  = -TOne;

  localparam logic signed [1:0] NormPos  = 2'sb01;
  localparam logic signed [1:0] NormNeg  = 2'sb11;
  localparam logic signed [1:0] NormZero = 2'sb00;

  localparam logic signed [SW-1:0] CMax = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMin = ~CMax;

  function automatic logic signed [TW-1:0] slab_time(
    input logic [QB-1:0] q,
    input logic          rnz,
    input logic          ovf,
    input logic          neg
  );
    logic        [TW-1:0] c;
    logic signed [TW-1:0] t;
    c = {1'b0, q} + TW'(rnz);
    if (!neg) begin
      if (ovf || ({1'b0, q} > THigh)) t = THigh;
      else t = {1'b0, q};
    end else begin
      if (ovf || (c > TOne)) t = TLow;
      else t = -c;
    end
    return t;
  endfunction

  // stage 1: slab times, unbounded slabs, ordering
  logic signed [TW-1:0] txn, txf, tyn, tyf;
  logic signed [TW-1:0] nx_d, fx_d, ny_d, fy_d;
  logic                 ok1_d;

  always_comb begin
    txn = slab_time(qxn_i, rnz_i[0], ovf_i[0], flags_i.negxn);
    txf = slab_time(qxf_i, rnz_i[1], ovf_i[1], flags_i.negxf);
    tyn = slab_time(qyn_i, rnz_i[2], ovf_i[2], flags_i.negyn);
    tyf = slab_time(qyf_i, rnz_i[3], ovf_i[3], flags_i.negyf);
    if (flags_i.zx) begin
      nx_d = TLow;
      fx_d = THigh;
    end else if (txn > txf) begin
      nx_d = txf;
      fx_d = txn;
    end else begin
      nx_d = txn;
      fx_d = txf;
    end
    if (flags_i.zy) begin
      ny_d = TLow;
      fy_d = THigh;
    end else if (tyn > tyf) begin
      ny_d = tyf;
      fy_d = tyn;
    end else begin
      ny_d = tyn;
      fy_d = tyf;
    end
    ok1_d = !flags_i.vzero && (!flags_i.zx || flags_i.inx) && (!flags_i.zy || flags_i.iny);
  end

  logic signed [TW-1:0] nx1_q, fx1_q, ny1_q, fy1_q;
  logic                 ok1_q;
  logic signed [CW:0]   cx1_q, cy1_q;
  logic signed [CW-1:0] vx1_q, vy1_q;
  logic        [EW-1:0] el1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      nx1_q <= nx_d;
      fx1_q <= fx_d;
      ny1_q <= ny_d;
      fy1_q <= fy_d;
      ok1_q <= ok1_d;
      cx1_q <= cx_i;
      cy1_q <= cy_i;
      vx1_q <= vx_i;
      vy1_q <= vy_i;
      el1_q <= el_i;
    end
  end

  // stage 2: overlap, hit window, normal
  logic                 xgt, xlt;
  logic signed [TW-1:0] tnear, tfar;
  logic                 hit2_d;
  logic signed [1:0]    nrx2_d, nry2_d;

  always_comb begin
    xgt    = (nx1_q > ny1_q);
    xlt    = (nx1_q < ny1_q);
    tnear  = xgt ? nx1_q : ny1_q;
    tfar   = (fx1_q < fy1_q) ? fx1_q : fy1_q;
    hit2_d = ok1_q && !(nx1_q > fy1_q) && !(ny1_q > fx1_q) && !tfar[TW-1]
             && !tnear[TW-1] && (tnear <= TOne);
    nrx2_d = xgt ? (vx1_q[CW-1] ? NormPos : NormNeg) : NormZero;
    nry2_d = xlt ? (vy1_q[CW-1] ? NormPos : NormNeg) : NormZero;
  end

  logic                 hit2_q;
  logic        [EW-1:0] tn2_q, el2_q;
  logic signed [1:0]    nrx2_q, nry2_q;
  logic signed [CW:0]   cx2_q, cy2_q;
  logic signed [CW-1:0] vx2_q, vy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      hit2_q <= hit2_d;
      tn2_q  <= tnear[EW-1:0];
      nrx2_q <= nrx2_d;
      nry2_q <= nry2_d;
      el2_q  <= el1_q;
      cx2_q  <= cx1_q;
      cy2_q  <= cy1_q;
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
    end
  end

  // stage 3: seconds elapsed at contact
  logic [2*EW-1:0] pt;

  assign pt = (2*EW)'(tn2_q) * (2*EW)'(el2_q);

  logic                 hit3_q;
  logic        [EW-1:0] tn3_q, s3_q;
  logic signed [1:0]    nrx3_q, nry3_q;
  logic signed [CW:0]   cx3_q, cy3_q;
  logic signed [CW-1:0] vx3_q, vy3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      hit3_q <= hit2_q;
      tn3_q  <= tn2_q;
      s3_q   <= pt[TF +: EW];
      nrx3_q <= nrx2_q;
      nry3_q <= nry2_q;
      cx3_q  <= cx2_q;
      cy3_q  <= cy2_q;
      vx3_q  <= vx2_q;
      vy3_q  <= vy2_q;
    end
  end

  // stage 4: displacement, floor of v * s
  logic signed [PW-1:0] px, py;
  logic signed [EW:0]   s_sgn;

  assign s_sgn = $signed({1'b0, s3_q});
  assign px    = PW'(vx3_q) * PW'(s_sgn);
  assign py    = PW'(vy3_q) * PW'(s_sgn);

  logic                  hit4_q;
  logic        [EW-1:0]  tn4_q;
  logic signed [1:0]     nrx4_q, nry4_q;
  logic signed [CW:0]    cx4_q, cy4_q;
  logic signed [DPW-1:0] dx4_q, dy4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      hit4_q <= hit3_q;
      tn4_q  <= tn3_q;
      nrx4_q <= nrx3_q;
      nry4_q <= nry3_q;
      cx4_q  <= cx3_q;
      cy4_q  <= cy3_q;
      dx4_q  <= px[TF +: DPW];
      dy4_q  <= py[TF +: DPW];
    end
  end

  // stage 5: contact point with saturation, result register
  logic signed [SW-1:0] sx, sy;
  logic signed [CW-1:0] ccx, ccy;

  assign sx = SW'(cx4_q) + SW'(dx4_q);
  assign sy = SW'(cy4_q) + SW'(dy4_q);

  always_comb begin
    if (sx > CMax) ccx = CMax[CW-1:0];
    else if (sx < CMin) ccx = CMin[CW-1:0];
    else ccx = sx[CW-1:0];
    if (sy > CMax) ccy = CMax[CW-1:0];
    else if (sy < CMin) ccy = CMin[CW-1:0];
    else ccy = sy[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      hit_o        <= hit4_q;
      contact_x_o  <= hit4_q ? ccx : '0;
      contact_y_o  <= hit4_q ? ccy : '0;
      normal_x_o   <= hit4_q ? nrx4_q : NormZero;
      normal_y_o   <= hit4_q ? nry4_q : NormZero;
      touch_time_o <= hit4_q ? tn4_q : '0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sbct_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sbct_checker #(
  parameter int unsigned CW = sbct_pkg::DefCoordWidth,
  parameter int unsigned TF = sbct_pkg::DefTimeFracBits
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 hit_i,
  input logic signed [CW-1:0] contact_x_i,
  input logic signed [CW-1:0] contact_y_i,
  input logic signed [1:0]    normal_x_i,
  input logic signed [1:0]    normal_y_i,
  input logic        [TF:0]   touch_time_i
);

  localparam logic [TF:0] TOne = (TF+1)'(1) << TF;

  logic [2*CW+TF+5:0] pay;
  logic               stall;
  logic               miss_clean;
  logic               hit_shape;

  assign pay   = {hit_i, contact_x_i, contact_y_i, normal_x_i, normal_y_i, touch_time_i};
  assign stall = out_valid_i && !out_ready_i;

  assign miss_clean = (contact_x_i == '0) && (contact_y_i == '0) && (normal_x_i == '0)
                      && (normal_y_i == '0) && (touch_time_i == '0);
  assign hit_shape  = (touch_time_i <= TOne) && !((normal_x_i != '0) && (normal_y_i != '0))
                      && (normal_x_i != 2'sb10) && (normal_y_i != 2'sb10);

  `SBCT_ASSERT(a_out_hold, clk_i, rst_ni, stall |=> out_valid_i, "result dropped while stalled")
  `SBCT_ASSERT_STABLE(a_out_stable, clk_i, rst_ni, stall, pay, "result changed while stalled")
  `SBCT_ASSERT(a_miss_zero, clk_i, rst_ni, out_valid_i && !hit_i |-> miss_clean, "miss not clear")
  `SBCT_ASSERT(a_hit_shape, clk_i, rst_ni, out_valid_i && hit_i |-> hit_shape, "bad hit result")

endmodule

bind swept_box_collision_test_core sbct_checker #(
  .CW (COORD_WIDTH),
  .TF (TIME_FRAC_BITS)
) u_sbct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .hit_i        (out_o.hit),
  .contact_x_i  (out_o.contact_x),
  .contact_y_i  (out_o.contact_y),
  .normal_x_i   (out_o.normal_x),
  .normal_y_i   (out_o.normal_y),
  .touch_time_i (out_o.touch_time)
);

`default_nettype wire
